// ===== rtl/core/dse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_pkg - shared definitions for the dual stack engine
// Sizes, operation and status codes, state machine type and the command
// bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package dse_pkg;

  localparam int DEPTH      = 128;
  localparam int WORD_WIDTH = 32;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEP   = 2'd2,
    MODE_MODIFY = 2'd3
  } dse_mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } dse_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } dse_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // perform the stack access and update the count
    logic present;  // drive the result onto the output ports
  } dse_cmd_t;

endpackage

// ===== rtl/core/dual_stack_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_engine - two independent LIFO stacks of signed words
// Push, pop, peep and modify on either of two stacks, one request at a time.
// ----------------------------------------------------------------------------
//
// Usage. A request is taken at a rising edge where start is high and busy
// is low; in_mode picks push, pop, peep or modify, in_stack_sel picks the
// stack, in_depth_pos gives the 1-based position from the top for peep and
// modify, and in_data_in carries the word for push and modify.
//
// Every request produces exactly one result. It appears on out_data_out,
// out_status and out_fill_count for a single cycle, flagged by out_valid,
// in the result cycle once the memory access is done, and is taken at the
// edge that ends that cycle. The receiver cannot hold it off, so there is
// no stall path on the output side. A request passes through the cycle in
// which it is taken, the single memory access of the selected stack store,
// and presentation of the result. Busy stays high through the access and
// result cycles, so the next request can be taken only once the block is
// back in idle, never before the result of the last one has been shown.
//
// Full, empty and out-of-range position cases leave the stacks untouched
// and are reported through out_status, with out_data_out held at zero.
// Reset empties both stacks by clearing their fill counts; the stores are
// not cleared, since only pushed entries can ever be addressed.
//
module dual_stack_engine
  import dse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic               in_stack_sel,
  input  logic [7:0]         in_depth_pos,
  input  logic signed [31:0] in_data_in,
  output logic               out_valid,
  output logic signed [31:0] out_data_out,
  output logic [1:0]         out_status,
  output logic [7:0]         out_fill_count
);

  dse_cmd_t cmd;

  // The controller sequences each request; the datapath owns all storage.
  dse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  dse_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_stack_sel   (in_stack_sel),
    .in_depth_pos   (in_depth_pos),
    .in_data_in     (in_data_in),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  assign out_valid = cmd.present;

  // An accepted request always makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // An accepted request is always followed by its result, after the execution state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing two cycles after request");

  // A failed operation never returns data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_data_out == '0))
    else $error("data returned with a failure status");

  // A full report means the stack holds exactly DEPTH entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (out_fill_count == 8'(DEPTH)))
    else $error("full status with a short stack");

endmodule

// ===== rtl/core/dse_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_ctrl - request sequencer
// Steps each request through capture, execution and result presentation.
// ----------------------------------------------------------------------------
module dse_ctrl
  import dse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dse_cmd_t cmd
);

  dse_state_t state_r;
  dse_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.present = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_RESP: begin
        cmd.present = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/dse_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_datapath - stack storage, fill counts and result registers
// Holds both stores as single-port memories with registered reads, checks
// each request against the selected fill count and forms the result.
// ----------------------------------------------------------------------------
module dse_datapath
  import dse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dse_cmd_t           cmd,
  input  logic [1:0]         in_mode,
  input  logic               in_stack_sel,
  input  logic [POS_W-1:0]   in_depth_pos,
  input  logic signed [31:0] in_data_in,
  output logic signed [31:0] out_data_out,
  output logic [1:0]         out_status,
  output logic [7:0]         out_fill_count
);

  // Captured request.
  dse_mode_t             mode_r;
  logic                  sel_r;
  logic [POS_W-1:0]      pos_r;
  logic [WORD_WIDTH-1:0] word_r;

  // Fill counts.
  logic [CNT_W-1:0] cnt_a_r;
  logic [CNT_W-1:0] cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r;
  logic [CNT_W-1:0] cnt_b_nxt;

  // Result registers.
  dse_status_t           status_r;
  logic [7:0]            fill_r;
  logic                  rd_ok_r;
  logic [WORD_WIDTH-1:0] rd_a_r;
  logic [WORD_WIDTH-1:0] rd_b_r;

  logic [WORD_WIDTH-1:0] mem_a [DEPTH];
  logic [WORD_WIDTH-1:0] mem_b [DEPTH];

  // Access decode.
  logic [CNT_W-1:0]  n_cur;
  logic [CNT_W-1:0]  n_new;
  logic [CMP_W-1:0]  n_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  logic              rd_ok;
  dse_status_t       status;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= dse_mode_t'(in_mode);
      sel_r  <= in_stack_sel;
      pos_r  <= in_depth_pos;
      word_r <= WORD_WIDTH'($unsigned(in_data_in));
    end
  end

  assign n_cur   = sel_r ? cnt_b_r : cnt_a_r;
  assign n_ext   = CMP_W'(n_cur);
  assign pos_ext = CMP_W'(pos_r);
  assign idx_ext = n_ext - pos_ext;

  always_comb begin
    n_new  = n_cur;
    addr   = n_cur[ADDR_W-1:0];
    wr_en  = 1'b0;
    rd_ok  = 1'b0;
    status = STAT_OK;
    case (mode_r)
      MODE_PUSH: begin
        if (n_cur == CNT_W'(DEPTH)) begin
          status = STAT_FULL;
        end else begin
          wr_en = 1'b1;
          n_new = n_cur + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (n_cur == '0) begin
          status = STAT_EMPTY;
        end else begin
          n_new = n_cur - CNT_W'(1);
          addr  = n_new[ADDR_W-1:0];
          rd_ok = 1'b1;
        end
      end
      default: begin
        addr = idx_ext[ADDR_W-1:0];
        if (pos_ext == '0 || pos_ext > n_ext) begin
          status = STAT_BADPOS;
        end else if (mode_r == MODE_PEEP) begin
          rd_ok = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (cmd.exec) begin
      if (sel_r) begin
        cnt_b_nxt = n_new;
      end else begin
        cnt_a_nxt = n_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en && !sel_r) begin
        mem_a[addr] <= word_r;
      end
      rd_a_r <= mem_a[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en && sel_r) begin
        mem_b[addr] <= word_r;
      end
      rd_b_r <= mem_b[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status;
      fill_r   <= n_new[7:0];
      rd_ok_r  <= rd_ok;
    end
  end

  assign out_data_out   = (cmd.present && rd_ok_r) ? 32'(sel_r ? rd_b_r : rd_a_r) : '0;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;

endmodule

// ===== tb/sv/dual_stack_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_engine_tb - self-checking testbench for the dual stack engine
// A short table of directed requests covers both stacks, the word extremes
// and the empty and bad-position statuses. Random mixed segments,
// fill-to-full runs and drain-to-empty runs follow. Each result is checked
// against its table row or a behavioural model of both stacks kept with the stimulus.
// ----------------------------------------------------------------------------
module dual_stack_engine_tb
  import dse_pkg::*;
();

  // Stimulus sizing and the inactivity limit. The slowest correct request is
  // the longest idle gap that pick_gap draws plus the time spent in the block,
  // so the limit below leaves a wide margin.
  localparam int RANDOM_ITEMS   = 900;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_PRINTED    = 40;
  localparam int DRAIN_CYCLES   = 8;

  // One request as it is presented on the input ports.
  typedef struct packed {
    dse_mode_t          mode;
    logic               sel;
    logic [7:0]         pos;
    logic signed [31:0] data;
  } stack_req_t;

  // One result as it appears on the output ports.
  typedef struct packed {
    logic signed [31:0] data;
    dse_status_t        status;
    logic [7:0]         fill;
  } stack_resp_t;

  // A row of the directed table. Where checked is set, the expected result
  // is taken from the row itself rather than from the model.
  typedef struct packed {
    stack_req_t  req;
    logic        checked;
    stack_resp_t want;
  } stim_row_t;

  typedef enum int {
    SEG_MIX,
    SEG_FILL,
    SEG_DRAIN
  } seg_kind_t;

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [1:0]         in_mode        = '0;
  logic               in_stack_sel   = 1'b0;
  logic [7:0]         in_depth_pos   = '0;
  logic signed [31:0] in_data_in     = '0;
  logic               out_valid;
  logic signed [31:0] out_data_out;
  logic [1:0]         out_status;
  logic [7:0]         out_fill_count;

  // Model state: the words of both stacks and their fill counts.
  logic signed [31:0] stack_words [2][DEPTH];
  int unsigned        stack_fill  [2];

  stack_resp_t        pending_results [$];
  stim_row_t          dir_table [$];
  int                 mismatch_count = 0;
  int                 stall_cycles   = 0;
  bit                 quiet_seg      = 1'b0;

  dual_stack_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_stack_sel   (in_stack_sel),
    .in_depth_pos   (in_depth_pos),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the two-stack model and returns the result that
  // the block must give for it. Failed operations leave the stacks as they
  // were; data is zero unless a pop or a peep succeeds.
  function automatic stack_resp_t predict_stack(stack_req_t r);
    stack_resp_t p;
    int unsigned n;
    int unsigned idx;
    int          s;
    s        = int'(r.sel);
    n        = stack_fill[s];
    p.data   = '0;
    p.status = STAT_OK;
    case (r.mode)
      MODE_PUSH: begin
        if (n >= DEPTH) begin
          p.status = STAT_FULL;
        end else begin
          stack_words[s][n] = r.data;
          n++;
        end
      end
      MODE_POP: begin
        if (n == 0) begin
          p.status = STAT_EMPTY;
        end else begin
          n--;
          p.data = stack_words[s][n];
        end
      end
      default: begin
        // Positions count from 1 at the top; 0 and anything deeper than the
        // current fill are rejected for both peep and modify.
        if (r.pos == 8'd0 || 32'(r.pos) > n) begin
          p.status = STAT_BADPOS;
        end else begin
          idx = n - 32'(r.pos);
          if (r.mode == MODE_PEEP) begin
            p.data = stack_words[s][idx];
          end else begin
            stack_words[s][idx] = r.data;
          end
        end
      end
    endcase
    stack_fill[s] = n;
    p.fill        = n[7:0];
    return p;
  endfunction

  function automatic stim_row_t stim_row(dse_mode_t m, logic sel, int pos,
                                         logic [31:0] data, logic chk,
                                         logic [31:0] d_want, dse_status_t st,
                                         int fill);
    stim_row_t t;
    t.req.mode    = m;
    t.req.sel     = sel;
    t.req.pos     = pos[7:0];
    t.req.data    = data;
    t.checked     = chk;
    t.want.data   = d_want;
    t.want.status = st;
    t.want.fill   = fill[7:0];
    return t;
  endfunction

  // Most gaps are absent or short, a few are long. Quiet segments run with
  // no gaps at all, so the block sees back-to-back requests too.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_seg || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // Chooses a position for peep and modify: mostly a valid one, otherwise
  // zero, one past the fill, or anything at all.
  function automatic logic [7:0] pick_depth(logic sel);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = stack_fill[sel];
    if (r < 80 && n > 0) begin
      return 8'($urandom_range(1, n));
    end else if (r < 85) begin
      return '0;
    end else if (r < 90) begin
      return 8'((n < 255) ? n + 1 : 255);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic stack_req_t make_req(dse_mode_t m, logic sel);
    stack_req_t r;
    r.mode = m;
    r.sel  = sel;
    r.data = pick_word();
    // Push and pop ignore the position, so it carries noise for them.
    if (m == MODE_PEEP || m == MODE_MODIFY) begin
      r.pos = pick_depth(sel);
    end else begin
      r.pos = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  // Presents one request, holds it until the block takes it, and queues the
  // result that is due. While start is low the input ports carry noise.
  task automatic send_req(stack_req_t r, logic has_want, stack_resp_t want);
    int          gap;
    stack_resp_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      start        <= 1'b0;
      in_mode      <= 2'($urandom_range(0, 3));
      in_stack_sel <= 1'($urandom_range(0, 1));
      in_depth_pos <= 8'($urandom_range(0, 255));
      in_data_in   <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_mode      <= r.mode;
    in_stack_sel <= r.sel;
    in_depth_pos <= r.pos;
    in_data_in   <= r.data;
    do @(posedge clk); while (busy);
    predicted = predict_stack(r);
    pending_results.push_back(has_want ? want : predicted);
  endtask

  // One random segment. A mixed segment runs for a random length; a fill
  // segment pushes one stack to full and keeps knocking on it; a drain
  // segment pops until empty and then pops a little more.
  task automatic random_segment(output int sent);
    seg_kind_t   kind;
    logic        sel;
    int          len;
    int          r;
    int          refused;
    dse_mode_t   m;
    stack_resp_t none;
    none      = '0;
    sent      = 0;
    refused   = 0;
    r         = $urandom_range(0, 9);
    kind      = (r < 6) ? SEG_MIX : (r < 8) ? SEG_FILL : SEG_DRAIN;
    sel       = 1'($urandom_range(0, 1));
    quiet_seg = ($urandom_range(0, 9) < 3);
    len       = $urandom_range(10, 60);
    while ((kind == SEG_MIX && sent < len) || (kind != SEG_MIX && refused < 2)) begin
      r = $urandom_range(0, 99);
      case (kind)
        SEG_MIX: begin
          sel = 1'($urandom_range(0, 1));
          m   = (r < 35) ? MODE_PUSH : (r < 60) ? MODE_POP :
                (r < 85) ? MODE_PEEP : MODE_MODIFY;
        end
        SEG_FILL: begin
          m = (r < 85) ? MODE_PUSH : (r < 93) ? MODE_PEEP : MODE_MODIFY;
          if (m == MODE_PUSH && stack_fill[sel] == DEPTH) refused++;
        end
        default: begin
          m = (r < 85) ? MODE_POP : (r < 93) ? MODE_PEEP : MODE_MODIFY;
          if (m == MODE_POP && stack_fill[sel] == 0) refused++;
        end
      endcase
      send_req(make_req(m, sel), 1'b0, none);
      sent++;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Results cannot be held off, so each one is taken at the edge that ends
  // its strobe cycle and compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    stack_resp_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", out_data_out, '0);
      end else begin
        e = pending_results.pop_front();
        if (out_data_out !== e.data)
          report_mismatch("out_data_out", out_data_out, e.data);
        if (out_status !== e.status)
          report_mismatch("out_status", 32'(out_status), 32'(e.status));
        if (out_fill_count !== e.fill)
          report_mismatch("out_fill_count", 32'(out_fill_count), 32'(e.fill));
      end
    end
  end

  // The watchdog restarts on any accepted request or result, and ends the
  // run if the block goes silent for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no request or result taken for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int sent;
    int total;
    // Directed table. Results that follow plainly from reset, the extremes
    // or an error status are written in; the rest come from the model.
    dir_table.push_back(stim_row(MODE_POP,    0, 0, 32'h0,         1, 0, STAT_EMPTY,  0));
    dir_table.push_back(stim_row(MODE_POP,    1, 0, 32'hFFFF_FFFF, 1, 0, STAT_EMPTY,  0));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 1, 32'h0,         1, 0, STAT_BADPOS, 0));
    dir_table.push_back(stim_row(MODE_MODIFY, 1, 0, 32'h1234_5678, 1, 0, STAT_BADPOS, 0));
    dir_table.push_back(stim_row(MODE_PUSH,   0, 0, 32'h7FFF_FFFF, 1, 0, STAT_OK,     1));
    dir_table.push_back(stim_row(MODE_PUSH,   0, 255, 32'h8000_0000, 1, 0, STAT_OK,   2));
    dir_table.push_back(stim_row(MODE_PUSH,   1, 0, 32'h0000_0000, 1, 0, STAT_OK,     1));
    dir_table.push_back(stim_row(MODE_PUSH,   1, 0, 32'hFFFF_FFFF, 1, 0, STAT_OK,     2));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 1, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 2, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 0, 32'h0,         1, 0, STAT_BADPOS, 2));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 3, 32'h0,         1, 0, STAT_BADPOS, 2));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 255, 32'h0,       1, 0, STAT_BADPOS, 2));
    dir_table.push_back(stim_row(MODE_MODIFY, 0, 2, 32'h5A5A_5A5A, 1, 0, STAT_OK,     2));
    dir_table.push_back(stim_row(MODE_PEEP,   0, 2, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_MODIFY, 1, 1, 32'hFFFF_0000, 0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_MODIFY, 1, 3, 32'hA5A5_A5A5, 1, 0, STAT_BADPOS, 2));
    dir_table.push_back(stim_row(MODE_POP,    1, 0, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_POP,    1, 0, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_POP,    1, 0, 32'h0,         1, 0, STAT_EMPTY,  0));
    dir_table.push_back(stim_row(MODE_POP,    0, 0, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_POP,    0, 0, 32'h0,         0, 0, STAT_OK,     0));
    dir_table.push_back(stim_row(MODE_POP,    0, 0, 32'h0,         1, 0, STAT_EMPTY,  0));
    dir_table.push_back(stim_row(MODE_PEEP,   1, 1, 32'h0,         1, 0, STAT_BADPOS, 0));
    dir_table.push_back(stim_row(MODE_PUSH,   1, 128, 32'h0F0F_0F0F, 1, 0, STAT_OK,   1));

    // The model starts empty, as the block does after reset.
    stack_fill[0] = 0;
    stack_fill[1] = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      send_req(dir_table[i].req, dir_table[i].checked, dir_table[i].want);
    end

    total = 0;
    while (total < RANDOM_ITEMS) begin
      random_segment(sent);
      total += sent;
    end
    start <= 1'b0;

    // Wait for the last result, then keep the clock running for anything stray.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
